// ----- rtl/core/fmtq_pkg.sv -----
// ----------------------------------------------------------------------------
// fmtq_pkg
// Shared types and constants of the formant quality partition block.
// ----------------------------------------------------------------------------
`default_nettype none

package fmtq_pkg;

    localparam int unsigned HZ_W      = 16;  // frequency and bandwidth fields
    localparam int unsigned QMIN_W    = 16;  // Q8.8 quality threshold
    localparam int unsigned PROD_W    = 32;  // qmin * bw
    localparam int unsigned FRAC_W    = 8;   // fraction bits of qmin
    localparam int unsigned PCNT_W    = 5;   // pass_count field
    localparam int unsigned HOLD_W    = 2 * HZ_W;
    localparam int unsigned S_TDATA_W = 2 * HZ_W;
    localparam int unsigned M_TDATA_W = 40;  // 38 field bits padded to bytes
    localparam int unsigned STEP_W    = 4;   // counts HZ_W multiply steps

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QTEST,
        ST_EMIT,
        ST_ENDCHK,
        ST_FLRD,
        ST_FLOUT
    } state_t;

    // result of the shared quality-test unit
    typedef struct packed {
        logic done;
        logic pass;
    } qtest_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/formant_q_stable_partition.sv -----
// ----------------------------------------------------------------------------
// formant_q_stable_partition
// Per-frame formant quality partition: passing formants stream out at once,
// failing ones are held and flushed in arrival order at the frame end.
// ----------------------------------------------------------------------------
// One formant is taken at a time; s_tready is high only between formants.
// A formant that is outside the window or has zero bandwidth, or one dropped
// for overflow, does not use the quality unit. An in-window formant with
// nonzero bandwidth goes through the shared shift-add quality unit, one
// bandwidth bit per cycle, and is then emitted if it passes or held if it
// fails. At the frame end every held formant is read back from the hold RAM
// (read, then output register load). Output stalls can hold any beat. The
// result register carries one beat; the frame_done beat (m_tlast) holds
// pass_count and overflow. qmin_q8 is written through cfg_wen/cfg_wdata; the
// user must write it only while idle, which the block does not enforce.
`default_nettype none

module formant_q_stable_partition #(
    parameter int unsigned MAX_FORMANTS = 16
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // config
    input  wire logic                                 cfg_wen,
    input  wire logic [fmtq_pkg::QMIN_W-1:0]          cfg_wdata,   // qmin_q8
    // input stream
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [fmtq_pkg::S_TDATA_W-1:0]       s_tdata,     // freq_hz, bw_hz
    input  wire logic                                 s_tuser,     // in_window
    input  wire logic                                 s_tlast,     // frame_end
    // result stream
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [fmtq_pkg::M_TDATA_W-1:0]       m_tdata,     // out_freq_hz, out_bw_hz,
                                                                   // pass_count, overflow
    output logic                                      m_tuser,     // passed
    output logic                                      m_tlast      // frame_done
);

    localparam int unsigned CW = $clog2(MAX_FORMANTS + 1);
    localparam int unsigned AW = (MAX_FORMANTS > 1) ? $clog2(MAX_FORMANTS) : 1;
    localparam int unsigned EW = (CW > fmtq_pkg::PCNT_W) ? CW : fmtq_pkg::PCNT_W;
    localparam int unsigned HW = fmtq_pkg::HZ_W;

    fmtq_pkg::state_t               state_reg, state_next;
    logic [fmtq_pkg::QMIN_W-1:0]    qmin_reg;
    logic [CW-1:0]                  item_cnt_reg, item_cnt_next;
    logic [CW-1:0]                  hold_cnt_reg, hold_cnt_next;
    logic [CW-1:0]                  pass_cnt_reg, pass_cnt_next;
    logic                           ovf_reg, ovf_next;
    logic [CW-1:0]                  rd_idx_reg, rd_idx_next;
    logic [HW-1:0]                  freq_reg, freq_next;
    logic [HW-1:0]                  bw_reg, bw_next;
    logic                           end_reg, end_next;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [fmtq_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tuser_reg, m_tuser_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic                           s_accept;
    logic                           out_free;
    logic                           q_start;
    fmtq_pkg::qtest_res_t           q_res;
    logic                           ram_we;
    logic [fmtq_pkg::HOLD_W-1:0]    ram_rdata;
    logic [HW-1:0]                  in_freq;
    logic [HW-1:0]                  in_bw;
    logic [CW-1:0]                  pass_cnt_inc;

    function automatic logic [fmtq_pkg::PCNT_W-1:0] sat_cnt(input logic [CW-1:0] v);
        logic [EW-1:0] ext;
        ext = EW'(v);
        if (ext > EW'(31)) begin
            return fmtq_pkg::PCNT_W'(31);
        end
        return ext[fmtq_pkg::PCNT_W-1:0];
    endfunction

    function automatic logic [fmtq_pkg::M_TDATA_W-1:0] pack_out(
        input logic [HW-1:0]                  f,
        input logic [HW-1:0]                  b,
        input logic [fmtq_pkg::PCNT_W-1:0]    cnt,
        input logic                           ovf
    );
        return fmtq_pkg::M_TDATA_W'({ovf, cnt, b, f});
    endfunction

    assign in_freq      = s_tdata[HW-1:0];
    assign in_bw        = s_tdata[2*HW-1:HW];
    assign s_tready     = (state_reg == fmtq_pkg::ST_IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign out_free     = !m_tvalid_reg || m_tready;
    assign pass_cnt_inc = pass_cnt_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qmin_reg <= '0;
        end else if (cfg_wen) begin
            qmin_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fmtq_pkg::ST_IDLE;
            item_cnt_reg <= '0;
            hold_cnt_reg <= '0;
            pass_cnt_reg <= '0;
            ovf_reg      <= 1'b0;
            rd_idx_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            item_cnt_reg <= item_cnt_next;
            hold_cnt_reg <= hold_cnt_next;
            pass_cnt_reg <= pass_cnt_next;
            ovf_reg      <= ovf_next;
            rd_idx_reg   <= rd_idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        freq_reg    <= freq_next;
        bw_reg      <= bw_next;
        end_reg     <= end_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_comb begin
        state_next    = state_reg;
        item_cnt_next = item_cnt_reg;
        hold_cnt_next = hold_cnt_reg;
        pass_cnt_next = pass_cnt_reg;
        ovf_next      = ovf_reg;
        rd_idx_next   = rd_idx_reg;
        freq_next     = freq_reg;
        bw_next       = bw_reg;
        end_next      = end_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        q_start       = 1'b0;
        ram_we        = 1'b0;

        unique case (state_reg)
            fmtq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    freq_next = in_freq;
                    bw_next   = in_bw;
                    end_next  = s_tlast;
                    if (item_cnt_reg >= CW'(MAX_FORMANTS)) begin
                        ovf_next   = 1'b1;
                        state_next = fmtq_pkg::ST_ENDCHK;
                    end else begin
                        item_cnt_next = item_cnt_reg + 1'b1;
                        if (!s_tuser || in_bw == '0) begin
                            state_next = fmtq_pkg::ST_EMIT;
                        end else begin
                            q_start    = 1'b1;
                            state_next = fmtq_pkg::ST_QTEST;
                        end
                    end
                end
            end
            fmtq_pkg::ST_QTEST: begin
                if (q_res.done) begin
                    if (q_res.pass) begin
                        state_next = fmtq_pkg::ST_EMIT;
                    end else begin
                        ram_we        = 1'b1;
                        hold_cnt_next = hold_cnt_reg + 1'b1;
                        state_next    = fmtq_pkg::ST_ENDCHK;
                    end
                end
            end
            fmtq_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b1;
                    if (end_reg && hold_cnt_reg == '0) begin
                        // passing item closes the frame itself
                        m_tlast_next  = 1'b1;
                        m_tdata_next  = pack_out(freq_reg, bw_reg, sat_cnt(pass_cnt_inc),
                                                 ovf_reg);
                        item_cnt_next = '0;
                        pass_cnt_next = '0;
                        ovf_next      = 1'b0;
                        state_next    = fmtq_pkg::ST_IDLE;
                    end else begin
                        m_tlast_next  = 1'b0;
                        m_tdata_next  = pack_out(freq_reg, bw_reg, '0, 1'b0);
                        pass_cnt_next = pass_cnt_inc;
                        state_next    = fmtq_pkg::ST_ENDCHK;
                    end
                end
            end
            fmtq_pkg::ST_ENDCHK: begin
                if (!end_reg) begin
                    state_next = fmtq_pkg::ST_IDLE;
                end else if (hold_cnt_reg != '0) begin
                    rd_idx_next = '0;
                    state_next  = fmtq_pkg::ST_FLRD;
                end else if (out_free) begin
                    // nothing left to show: empty marker beat
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    m_tlast_next  = 1'b1;
                    m_tdata_next  = pack_out('0, '0, sat_cnt(pass_cnt_reg), ovf_reg);
                    item_cnt_next = '0;
                    pass_cnt_next = '0;
                    ovf_next      = 1'b0;
                    state_next    = fmtq_pkg::ST_IDLE;
                end
            end
            fmtq_pkg::ST_FLRD: begin
                state_next = fmtq_pkg::ST_FLOUT;
            end
            fmtq_pkg::ST_FLOUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = 1'b0;
                    if (rd_idx_reg + 1'b1 == hold_cnt_reg) begin
                        m_tlast_next  = 1'b1;
                        m_tdata_next  = pack_out(ram_rdata[2*HW-1:HW], ram_rdata[HW-1:0],
                                                 sat_cnt(pass_cnt_reg), ovf_reg);
                        item_cnt_next = '0;
                        hold_cnt_next = '0;
                        pass_cnt_next = '0;
                        ovf_next      = 1'b0;
                        state_next    = fmtq_pkg::ST_IDLE;
                    end else begin
                        m_tlast_next = 1'b0;
                        m_tdata_next = pack_out(ram_rdata[2*HW-1:HW], ram_rdata[HW-1:0],
                                                '0, 1'b0);
                        rd_idx_next  = rd_idx_reg + 1'b1;
                        state_next   = fmtq_pkg::ST_FLRD;
                    end
                end
            end
            default: begin
                state_next = fmtq_pkg::ST_IDLE;
            end
        endcase
    end

    fmtq_qtest u_qtest (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (q_start),
        .freq_hz (in_freq),
        .bw_hz   (in_bw),
        .qmin_q8 (qmin_reg),
        .res     (q_res)
    );

    // held formants: freq in the upper half, bandwidth in the lower half
    fmtq_ram #(
        .WIDTH (fmtq_pkg::HOLD_W),
        .DEPTH (MAX_FORMANTS)
    ) u_hold_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (hold_cnt_reg[AW-1:0]),
        .wdata ({freq_reg, bw_reg}),
        .raddr (rd_idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    hold_le_items_a: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_cnt_reg <= item_cnt_reg && item_cnt_reg <= CW'(MAX_FORMANTS))
        else $error("frame counters out of range");

    flush_has_data_a: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmtq_pkg::ST_FLRD || state_reg == fmtq_pkg::ST_FLOUT)
        |-> rd_idx_reg < hold_cnt_reg)
        else $error("flush read beyond held formants");

    qtest_owned_a: assert property (@(posedge aclk) disable iff (!aresetn)
        q_res.done |-> state_reg == fmtq_pkg::ST_QTEST)
        else $error("quality result arrived outside the test state");

    frame_clear_a: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_next && m_tlast_next && !(m_tvalid_reg && !m_tready)
        |=> item_cnt_reg == '0 && hold_cnt_reg == '0 && pass_cnt_reg == '0 && !ovf_reg)
        else $error("frame state not cleared after frame_done beat");

endmodule

`default_nettype wire

// ----- rtl/core/fmtq_ram.sv -----
// ----------------------------------------------------------------------------
// fmtq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        we,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/fmtq_qtest.sv -----
// ----------------------------------------------------------------------------
// fmtq_qtest
// Quality test unit: shift-add multiply of qmin by bandwidth, one bandwidth
// bit per cycle, then compare against freq * 256.
// ----------------------------------------------------------------------------
`default_nettype none

module fmtq_qtest (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [fmtq_pkg::HZ_W-1:0]     freq_hz,
    input  wire logic [fmtq_pkg::HZ_W-1:0]     bw_hz,
    input  wire logic [fmtq_pkg::QMIN_W-1:0]   qmin_q8,
    output fmtq_pkg::qtest_res_t               res
);

    logic                           busy_reg, busy_next;
    logic                           cmp_reg, cmp_next;
    logic                           done_reg, done_next;
    logic                           pass_reg, pass_next;
    logic [fmtq_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [fmtq_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [fmtq_pkg::HZ_W-1:0]      bw_sh_reg, bw_sh_next;
    logic [fmtq_pkg::HZ_W-1:0]      freq_reg, freq_next;
    logic [fmtq_pkg::PROD_W-1:0]    addend;
    logic [fmtq_pkg::PROD_W-1:0]    freq_scaled;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cmp_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            cmp_reg  <= cmp_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        pass_reg  <= pass_next;
        acc_reg   <= acc_next;
        bw_sh_reg <= bw_sh_next;
        freq_reg  <= freq_next;
    end

    assign addend      = bw_sh_reg[fmtq_pkg::HZ_W-1]
                         ? fmtq_pkg::PROD_W'(qmin_q8) : '0;
    assign freq_scaled = fmtq_pkg::PROD_W'({freq_reg, {fmtq_pkg::FRAC_W{1'b0}}});

    always_comb begin
        busy_next  = busy_reg;
        cmp_next   = 1'b0;
        done_next  = 1'b0;
        step_next  = step_reg;
        pass_next  = pass_reg;
        acc_next   = acc_reg;
        bw_sh_next = bw_sh_reg;
        freq_next  = freq_reg;
        if (start) begin
            busy_next  = 1'b1;
            step_next  = '0;
            acc_next   = '0;
            bw_sh_next = bw_hz;
            freq_next  = freq_hz;
        end else if (busy_reg) begin
            // MSB first: acc = 2*acc + bit*qmin
            acc_next   = {acc_reg[fmtq_pkg::PROD_W-2:0], 1'b0} + addend;
            bw_sh_next = {bw_sh_reg[fmtq_pkg::HZ_W-2:0], 1'b0};
            step_next  = step_reg + 1'b1;
            if (step_reg == '1) begin
                busy_next = 1'b0;
                cmp_next  = 1'b1;
            end
        end else if (cmp_reg) begin
            done_next = 1'b1;
            pass_next = (freq_scaled >= acc_reg);
        end
    end

    assign res = '{done: done_reg, pass: pass_reg};

    busy_no_done_a: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !cmp_reg && !done_reg)
        else $error("quality unit reports while still multiplying");

    cmp_then_done_a: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_reg && !start |=> done_reg)
        else $error("compare step did not produce a result");

    last_step_a: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start && step_reg == '1 |=> cmp_reg && !busy_reg)
        else $error("multiply did not end after the last bandwidth bit");

endmodule

`default_nettype wire

// ----- sim/tb_formant_q_stable_partition.sv -----
// ----------------------------------------------------------------------------
// tb_formant_q_stable_partition
// Self-checking bench for the formant quality partition. Frames of formants
// go in on the s_ stream, and a built-in predictor (pass test, hold list,
// frame counters) works out each expected beat. Every beat taken from the m_
// stream is compared field by field against the oldest prediction. A directed
// table comes first, then random frames under several qmin settings, with
// random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_formant_q_stable_partition;

    localparam int unsigned MAX_FMT     = 16;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE_CYC  = 40;    // settle wait after the expected beats drain
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned N_DIRECTED  = 25;
    localparam int unsigned N_PHASES    = 6;
    localparam int unsigned PHASE_ITEMS = 27;

    typedef struct packed {
        logic [fmtq_pkg::HZ_W-1:0]   freq;
        logic [fmtq_pkg::HZ_W-1:0]   bw;
        logic                        passed;
        logic                        done;
        logic [fmtq_pkg::PCNT_W-1:0] count;
        logic                        ovf;
    } formant_res_t;

    typedef struct packed {
        logic                        cfg_wr;    // write qmin before this row
        logic [fmtq_pkg::QMIN_W-1:0] cfg_val;
        logic [fmtq_pkg::HZ_W-1:0]   freq;
        logic [fmtq_pkg::HZ_W-1:0]   bw;
        logic                        win;
        logic                        last;
        logic                        has_exp;   // row carries its own single expected beat
        formant_res_t                exp_res;
    } stim_row_t;

    localparam formant_res_t NO_RES = '0;

    // qmin 0 after reset: everything passes. Then qmin = 10.0 (0x0A00).
    // The last frame overruns capacity with nothing held -> marker beat.
    localparam stim_row_t DIR_TAB [N_DIRECTED] = '{
        '{1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,
          '{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 5'd1, 1'b0}},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b1,
          '{16'h0000, 16'h0000, 1'b1, 1'b1, 5'd1, 1'b0}},
        '{1'b1, 16'h0A00, 16'd1000, 16'd50,   1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'd1000, 16'd200,  1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'd500,  16'd0,    1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'd300,  16'd100,  1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'd2000, 16'd200,  1'b1, 1'b1, 1'b0, NO_RES}, // exact tie
        '{1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'hFFFF, 16'h0001, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h5555, 16'hAAAA, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'hAAAA, 16'h5555, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'd2560, 16'd256,  1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h8000, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h0001, 16'h8000, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h1234, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'hFFFE, 16'h1999, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h00FF, 16'hFF00, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h7FFF, 16'h0CCC, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h0F0F, 16'h0000, 1'b1, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'hF0F0, 16'h00F0, 1'b0, 1'b0, 1'b0, NO_RES},
        '{1'b0, 16'h0000, 16'h0001, 16'h0001, 1'b1, 1'b0, 1'b0, NO_RES}, // dropped
        '{1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1,         // dropped, ends
          '{16'h0000, 16'h0000, 1'b0, 1'b1, 5'd16, 1'b1}}
    };

    // DUT signals
    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_wen;
    logic [fmtq_pkg::QMIN_W-1:0]    cfg_wdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [fmtq_pkg::S_TDATA_W-1:0] s_tdata;     // freq_hz, bw_hz
    logic                           s_tuser;     // in_window
    logic                           s_tlast;     // frame_end
    logic                           m_tvalid;
    logic                           m_tready;
    logic [fmtq_pkg::M_TDATA_W-1:0] m_tdata;     // out_freq_hz, out_bw_hz, pass_count, overflow
    logic                           m_tuser;     // passed
    logic                           m_tlast;     // frame_done

    // predictor state
    logic [fmtq_pkg::QMIN_W-1:0]    qmin_cur;
    logic [fmtq_pkg::HOLD_W-1:0]    held_fmts[$];
    int unsigned                    taken_cnt;
    int unsigned                    pass_cnt;
    logic                           ovf_seen;
    formant_res_t                   step_res[$];
    formant_res_t                   exp_formants[$];

    int unsigned                    cycle_cnt = 0;
    int unsigned                    mismatches = 0;
    int unsigned                    hold_reqs;
    int unsigned                    hold_served;
    logic                           tx_idle_en;
    logic                           rx_idle_en;

    formant_q_stable_partition #(
        .MAX_FORMANTS(MAX_FMT)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Quality partition of one formant; results land in step_res.
    task automatic predict_formant(input logic [fmtq_pkg::HZ_W-1:0] f,
                                   input logic [fmtq_pkg::HZ_W-1:0] bw,
                                   input logic win, input logic last);
        logic [fmtq_pkg::PROD_W-1:0] lhs;
        logic [fmtq_pkg::PROD_W-1:0] rhs;
        formant_res_t                r;
        lhs = fmtq_pkg::PROD_W'({f, 8'h00});
        rhs = fmtq_pkg::PROD_W'(qmin_cur) * fmtq_pkg::PROD_W'(bw);
        step_res.delete();
        if (taken_cnt >= MAX_FMT) begin
            ovf_seen = 1'b1;
        end else begin
            taken_cnt++;
            if (!win || bw == '0 || lhs >= rhs) begin
                r = '{f, bw, 1'b1, 1'b0, '0, 1'b0};
                step_res.push_back(r);
                pass_cnt++;
            end else begin
                held_fmts.push_back({f, bw});
            end
        end
        if (last) begin
            foreach (held_fmts[i]) begin
                r = '{held_fmts[i][31:16], held_fmts[i][15:0], 1'b0, 1'b0, '0, 1'b0};
                step_res.push_back(r);
            end
            if (step_res.size() == 0)
                step_res.push_back(NO_RES);
            step_res[$].done  = 1'b1;
            step_res[$].count = (pass_cnt > 31) ? 5'd31 : fmtq_pkg::PCNT_W'(pass_cnt);
            step_res[$].ovf   = ovf_seen;
            held_fmts.delete();
            taken_cnt = 0;
            pass_cnt  = 0;
            ovf_seen  = 1'b0;
        end
    endtask

    // Offer one formant from the next falling edge until it is taken.
    task automatic send_formant(input logic [fmtq_pkg::HZ_W-1:0] f,
                                input logic [fmtq_pkg::HZ_W-1:0] bw,
                                input logic win, input logic last);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {bw, f};
        s_tuser  = win;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        predict_formant(f, bw, win, last);
    endtask

    task automatic tx_gap(input int unsigned n);
        repeat (n) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            s_tdata  = fmtq_pkg::S_TDATA_W'($urandom);
            s_tuser  = 1'($urandom);
            s_tlast  = 1'($urandom);
        end
    endtask

    task automatic maybe_tx_gap();
        if (tx_idle_en && $urandom_range(0, 3) == 0)
            tx_gap($urandom_range(1, 19));
    endtask

    // Drain all beats, let the block settle, then load a new qmin.
    task automatic load_qmin(input logic [fmtq_pkg::QMIN_W-1:0] v);
        tx_gap(1);
        while (exp_formants.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
        cfg_wen   = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_wen   = 1'b0;
        cfg_wdata = fmtq_pkg::QMIN_W'($urandom);
        qmin_cur  = v;
    endtask

    // Bandwidth with weight on zero, the top code and small values.
    function automatic logic [fmtq_pkg::HZ_W-1:0] pick_bw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return fmtq_pkg::HZ_W'($urandom_range(1, 15));
            4:       return fmtq_pkg::HZ_W'($urandom);
            default: return fmtq_pkg::HZ_W'($urandom_range(1, 4000));
        endcase
    endfunction

    // Frequency either free or placed right around the pass threshold.
    function automatic logic [fmtq_pkg::HZ_W-1:0] pick_freq(
        input logic [fmtq_pkg::HZ_W-1:0] bw
    );
        logic [fmtq_pkg::PROD_W-1:0] thr;
        thr = (fmtq_pkg::PROD_W'(qmin_cur) * fmtq_pkg::PROD_W'(bw)) >> fmtq_pkg::FRAC_W;
        if ($urandom_range(0, 2) == 0 || thr > 32'hFFFE)
            return fmtq_pkg::HZ_W'($urandom);
        if (thr == 0)
            return fmtq_pkg::HZ_W'($urandom_range(0, 1));
        return fmtq_pkg::HZ_W'(thr + $urandom_range(0, 2) - 1);
    endfunction

    // output side: random stall bursts, plus the long hold-off on request
    initial begin
        m_tready    = 1'b0;
        hold_served = 0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_reqs) begin
                m_tready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_served++;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge aclk);
            end else begin
                m_tready = 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        formant_res_t got;
        formant_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tdata[15:0], m_tdata[31:16], m_tuser, m_tlast,
                    m_tdata[36:32], m_tdata[37]};
            if (exp_formants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected: f=%0d bw=%0d p=%0b d=%0b cnt=%0d ovf=%0b",
                             got.freq, got.bw, got.passed, got.done, got.count, got.ovf);
            end else begin
                want = exp_formants.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: exp f=%0d bw=%0d p=%0b d=%0b cnt=%0d ovf=%0b",
                                 want.freq, want.bw, want.passed, want.done, want.count,
                                 want.ovf);
                        $display("          got f=%0d bw=%0d p=%0b d=%0b cnt=%0d ovf=%0b",
                                 got.freq, got.bw, got.passed, got.done, got.count, got.ovf);
                    end
                end
            end
        end
    end

    initial begin
        logic [fmtq_pkg::QMIN_W-1:0] phase_qmin[N_PHASES];
        int unsigned                 sent;
        int unsigned                 flen;
        logic                        fwin;
        logic                        win;
        logic [fmtq_pkg::HZ_W-1:0]   f;
        logic [fmtq_pkg::HZ_W-1:0]   bw;

        aresetn    = 1'b0;
        cfg_wen    = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        s_tlast    = 1'b0;
        hold_reqs  = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        qmin_cur   = '0;
        taken_cnt  = 0;
        pass_cnt   = 0;
        ovf_seen   = 1'b0;

        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIR_TAB[i].cfg_wr)
                load_qmin(DIR_TAB[i].cfg_val);
            send_formant(DIR_TAB[i].freq, DIR_TAB[i].bw, DIR_TAB[i].win, DIR_TAB[i].last);
            if (DIR_TAB[i].has_exp)
                exp_formants.push_back(DIR_TAB[i].exp_res);
            else
                foreach (step_res[k]) exp_formants.push_back(step_res[k]);
            maybe_tx_gap();
        end

        phase_qmin = '{16'hFFFF, 16'h0100, fmtq_pkg::QMIN_W'($urandom), 16'h0A00, 16'h0000,
                       fmtq_pkg::QMIN_W'($urandom_range(1, 16'h2000))};
        for (int p = 0; p < N_PHASES; p++) begin
            load_qmin(phase_qmin[p]);
            if (p == 2)
                hold_reqs++;   // sender keeps offering while the output is held off
            if (p == N_PHASES - 1) begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                flen = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_FMT + 1, MAX_FMT + 4)
                                                   : $urandom_range(1, MAX_FMT);
                fwin = ($urandom_range(0, 4) != 0);
                for (int k = 0; k < flen; k++) begin
                    win = ($urandom_range(0, 9) == 0) ? !fwin : fwin;
                    bw  = pick_bw();
                    f   = pick_freq(bw);
                    send_formant(f, bw, win, k == flen - 1);
                    foreach (step_res[j]) exp_formants.push_back(step_res[j]);
                    maybe_tx_gap();
                end
                sent += flen;
            end
        end

        tx_gap(1);
        while (exp_formants.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYC) @(negedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/fmtq_pkg.sv
rtl/core/fmtq_ram.sv
rtl/core/fmtq_qtest.sv
rtl/core/formant_q_stable_partition.sv
sim/tb_formant_q_stable_partition.sv
